// ----- rtl/pic_pkg.sv -----
// Shared types and constants for the PID controller block.
`default_nettype none

package pic_pkg;

    // Field widths
    localparam int ValueW = 16;
    localparam int GainW  = 16;
    localparam int LimitW = 15;
    localparam int ErrW   = 17;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // Incremental accumulator ceiling, Q.8
    localparam int IncMaxQ8 = 499 * 256;
    localparam int IncAccW  = 17;
    localparam int IntegW   = 24;

    // Limit reset value
    localparam logic [LimitW-1:0] LimitReset = 15'h7FFF;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_MODE        = 3'd0,
        CFG_GAIN_PROP   = 3'd1,
        CFG_GAIN_INTEG  = 3'd2,
        CFG_GAIN_DERIV  = 3'd3,
        CFG_DRIVE_LIMIT = 3'd4,
        CFG_INTEG_LIMIT = 3'd5
    } pic_cfg_idx_t;

    // Item kinds
    localparam logic KindSample = 1'b0;
    localparam logic KindClear  = 1'b1;

    // Configuration seen by the datapath
    typedef struct packed {
        logic              mode_positional;
        logic [GainW-1:0]  gain_prop;
        logic [GainW-1:0]  gain_integ;
        logic [GainW-1:0]  gain_deriv;
        logic [LimitW-1:0] drive_limit;
        logic [LimitW-1:0] integ_limit;
    } pic_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/pic_if.sv -----
// Handshake interfaces for the sample and result channels.
`default_nettype none

interface pic_sample_if;
    import pic_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [ValueW-1:0] measured;
    logic signed [ValueW-1:0] setpoint;

    modport source (output valid, output kind, output measured, output setpoint,
                    input ready);
    modport sink   (input valid, input kind, input measured, input setpoint,
                    output ready);
endinterface

interface pic_result_if;
    import pic_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ValueW-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ----- rtl/pic_cfg.sv -----
// Configuration register file of the PID controller.
`default_nettype none

module pic_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [pic_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [pic_pkg::CfgDataW-1:0] cfg_data,
    output pic_pkg::pic_cfg_t                 cfg_regs
);
    import pic_pkg::*;

    pic_cfg_t cfg_reg;

    // Write the addressed register; ignore unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_positional <= 1'b0;
            cfg_reg.gain_prop       <= '0;
            cfg_reg.gain_integ      <= '0;
            cfg_reg.gain_deriv      <= '0;
            cfg_reg.drive_limit     <= LimitReset;
            cfg_reg.integ_limit     <= LimitReset;
        end
        else if (cfg_we)
        begin
            unique case (pic_cfg_idx_t'(cfg_index))
                CFG_MODE:        cfg_reg.mode_positional <= cfg_data[0];
                CFG_GAIN_PROP:   cfg_reg.gain_prop       <= cfg_data;
                CFG_GAIN_INTEG:  cfg_reg.gain_integ      <= cfg_data;
                CFG_GAIN_DERIV:  cfg_reg.gain_deriv      <= cfg_data;
                CFG_DRIVE_LIMIT: cfg_reg.drive_limit     <= cfg_data[LimitW-1:0];
                CFG_INTEG_LIMIT: cfg_reg.integ_limit     <= cfg_data[LimitW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_regs = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/pic_core.sv -----
// PID datapath: error history, accumulators and the drive calculation.
`default_nettype none

module pic_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pic_pkg::pic_cfg_t                cfg_regs,
    input  wire logic                             fire,
    input  wire logic                             kind,
    input  wire logic signed [pic_pkg::ValueW-1:0] measured,
    input  wire logic signed [pic_pkg::ValueW-1:0] setpoint,
    output logic signed [pic_pkg::ValueW-1:0]     drive_next
);
    import pic_pkg::*;

    localparam logic signed [37:0] IncMaxWide = 38'(IncMaxQ8);
    localparam logic [IncAccW-1:0] IncMax     = IncAccW'(IncMaxQ8);

    // Controller state
    logic signed [ErrW-1:0]   last_err_reg;
    logic signed [ErrW-1:0]   prev_err_reg;
    logic signed [IntegW-1:0] integ_acc_reg;
    logic [IncAccW-1:0]       inc_acc_reg;

    logic signed [ErrW-1:0]   err;
    logic signed [17:0]       diff1;
    logic signed [18:0]       diff2;
    logic signed [18:0]       kp_op;
    logic signed [18:0]       kd_op;
    logic signed [34:0]       prod_kp;
    logic signed [32:0]       prod_ki;
    logic signed [34:0]       prod_kd;
    logic signed [37:0]       inc_sum;
    logic [IncAccW-1:0]       inc_next;
    logic signed [IntegW-1:0] integ_lim;
    logic signed [IntegW-1:0] drive_lim;
    logic signed [33:0]       integ_sum;
    logic signed [IntegW-1:0] integ_next;
    logic signed [36:0]       pos_sum;
    logic signed [IntegW-1:0] pos_out;

    // Error and its first and second differences
    always_comb
    begin
        err   = {setpoint[ValueW-1], setpoint} - {measured[ValueW-1], measured};
        diff1 = {err[ErrW-1], err} - {last_err_reg[ErrW-1], last_err_reg};
        diff2 = {{2{err[ErrW-1]}}, err}
              - {last_err_reg[ErrW-1], last_err_reg, 1'b0}
              + {{2{prev_err_reg[ErrW-1]}}, prev_err_reg};
    end

    // Pick multiplier operands for the selected form
    always_comb
    begin
        if (cfg_regs.mode_positional)
        begin
            kp_op = {{2{err[ErrW-1]}}, err};
            kd_op = {diff1[17], diff1};
        end
        else
        begin
            kp_op = {diff1[17], diff1};
            kd_op = diff2;
        end
    end

    // Three gain multiplies
    assign prod_kp = $signed(cfg_regs.gain_prop)  * kp_op;
    assign prod_ki = $signed(cfg_regs.gain_integ) * err;
    assign prod_kd = $signed(cfg_regs.gain_deriv) * kd_op;

    // Incremental form: add the delta and saturate to 0 .. 499
    always_comb
    begin
        inc_sum = $signed({21'd0, inc_acc_reg}) + 38'(prod_kp) + 38'(prod_ki)
                + 38'(prod_kd);
        if (inc_sum < 38'sd0)
            inc_next = '0;
        else if (inc_sum > IncMaxWide)
            inc_next = IncMax;
        else
            inc_next = inc_sum[IncAccW-1:0];
    end

    // Positional form: clamp the integral, then clamp the sum
    always_comb
    begin
        integ_lim = {1'b0, cfg_regs.integ_limit, 8'h00};
        drive_lim = {1'b0, cfg_regs.drive_limit, 8'h00};
        integ_sum = 34'(integ_acc_reg) + 34'(prod_ki);
        if (integ_sum > 34'(integ_lim))
            integ_next = integ_lim;
        else if (integ_sum < 34'(-integ_lim))
            integ_next = -integ_lim;
        else
            integ_next = integ_sum[IntegW-1:0];

        pos_sum = 37'(prod_kp) + 37'(prod_kd) + 37'(integ_next);
        if (pos_sum > 37'(drive_lim))
            pos_out = drive_lim;
        else if (pos_sum < 37'(-drive_lim))
            pos_out = -drive_lim;
        else
            pos_out = pos_sum[IntegW-1:0];
    end

    // Drive value: integer part of the Q.8 result
    always_comb
    begin
        if (kind == KindClear)
            drive_next = '0;
        else if (cfg_regs.mode_positional)
            drive_next = pos_out[IntegW-1:8];
        else
            drive_next = {7'd0, inc_next[IncAccW-1:8]};
    end

    // Advance the state when an item leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg  <= '0;
            prev_err_reg  <= '0;
            integ_acc_reg <= '0;
            inc_acc_reg   <= '0;
        end
        else if (fire)
        begin
            if (kind == KindClear)
            begin
                last_err_reg  <= '0;
                prev_err_reg  <= '0;
                integ_acc_reg <= '0;
            end
            else if (cfg_regs.mode_positional)
            begin
                integ_acc_reg <= integ_next;
                last_err_reg  <= err;
            end
            else
            begin
                inc_acc_reg  <= inc_next;
                prev_err_reg <= last_err_reg;
                last_err_reg <= err;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pid_controller_inc_pos.sv -----
// PID controller top level: input stage, datapath and result register.
//
// Takes one item per clock cycle in steady state while result ready is high.
// An accepted item waits in the input register until the result register is
// free or being drained; then the error history and accumulator update
// together with the result register. The combinational path from the state
// registers through the gain multiplies, accumulation and saturation back
// into the state registers sets this rate. Sample ready follows result ready
// combinationally, so a stalled output holds at most two items in flight.
// Configuration writes take effect on the next edge and belong to idle time.
`default_nettype none

module pid_controller_inc_pos (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [pic_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [pic_pkg::CfgDataW-1:0] cfg_data,
    pic_sample_if.sink                        sample,
    pic_result_if.source                      result
);
    import pic_pkg::*;

    pic_cfg_t cfg_regs;

    logic                     in_valid_reg;
    logic                     kind_reg;
    logic signed [ValueW-1:0] measured_reg;
    logic signed [ValueW-1:0] setpoint_reg;
    logic                     out_valid_reg;
    logic signed [ValueW-1:0] drive_reg;
    logic signed [ValueW-1:0] drive_next;
    logic                     fire;

    pic_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_regs  (cfg_regs)
    );

    // Move an item on when the result register is free or being drained
    assign fire         = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || fire;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.ready)
            in_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            kind_reg     <= sample.kind;
            measured_reg <= sample.measured;
            setpoint_reg <= sample.setpoint;
        end
    end

    pic_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_regs),
        .fire       (fire),
        .kind       (kind_reg),
        .measured   (measured_reg),
        .setpoint   (setpoint_reg),
        .drive_next (drive_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            drive_reg <= drive_next;
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

endmodule

`default_nettype wire

// ----- rtl/pic_checker.sv -----
// Port-level checks for the PID controller, bound to the top level.
`default_nettype none

module pic_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                sample_valid,
    input wire logic                                sample_ready,
    input wire logic                                result_valid,
    input wire logic                                result_ready,
    input wire logic signed [pic_pkg::ValueW-1:0]   result_drive
);
    import pic_pkg::*;

    logic [1:0] occupancy_reg;
    logic [1:0] occupancy_next;
    logic       took;
    logic       gave;

    // Track items inside the block
    assign took = sample_valid && sample_ready;
    assign gave = result_valid && result_ready;

    always_comb
    begin
        occupancy_next = occupancy_reg;
        if (took && !gave)
            occupancy_next = occupancy_reg + 2'd1;
        else if (gave && !took)
            occupancy_next = occupancy_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occupancy_reg <= '0;
        else
            occupancy_reg <= occupancy_next;
    end

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_drive))
    else $error("result changed while stalled");

    // No result without an item inside
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> occupancy_reg != 2'd0)
    else $error("result shown with no item in flight");

    // At most two items in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg != 2'd3)
    else $error("more than two items in flight");

    // A draining output never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
    else $error("input stalled while output drains");

endmodule

bind pid_controller_inc_pos pic_checker u_pic_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_drive (result.drive)
);

`default_nettype wire
